FILE: src/pdtm_pkg.sv
// ----------------------------------------------------------------------------
// pdtm_pkg: shared types and constants for the PWM duty to target map
// Configuration record, controller/datapath command and status records,
// and node table field extraction.
// ----------------------------------------------------------------------------
package pdtm_pkg;

    localparam logic [14:0] DUTY_MAX   = 15'h7FFF;
    localparam logic [15:0] CNT_SAT    = 16'hFFFF;
    localparam int          CFG_IDX_W  = 3;
    localparam int          CFG_DATA_W = 64;
    localparam int          NODE_IDX_W = 3;
    localparam int          STEP_CNT_W = 5;
    localparam logic [STEP_CNT_W-1:0] DIV1_STEPS = 5'd15;
    localparam logic [STEP_CNT_W-1:0] DIV2_STEPS = 5'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_PAIR_A   = 3'd0,
        CFG_NODE_PAIR_B   = 3'd1,
        CFG_NODE_PAIR_C   = 3'd2,
        CFG_NODE_PAIR_D   = 3'd3,
        CFG_START_DUTY    = 3'd4,
        CFG_STOP_DUTY     = 3'd5,
        CFG_FILTER_TICKS  = 3'd6,
        CFG_INVERT_DUTY   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [3:0][63:0] node_pair;
        logic [14:0]      start_duty;
        logic [14:0]      stop_duty;
        logic [15:0]      filter_ticks;
        logic             invert_duty;
    } t_cfg;

    typedef struct packed {
        logic in_load;   // latch the input transaction
        logic capt;      // capture check, prev update, divider setup
        logic div_step;  // one restoring division step
        logic duty_wr;   // write duty from quotient
        logic filt;      // run/stop hysteresis filters
        logic map;       // table end checks and segment select
        logic mul;       // slope product, divider setup
        logic interp;    // final target from quotient
        logic out_load;  // load result register
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic need_interp;
    } t_stat;

    function automatic logic [15:0] node_duty(input t_cfg c, input logic [NODE_IDX_W-1:0] i);
        logic [63:0] r;
        r = c.node_pair[i[2:1]];
        return i[0] ? r[47:32] : r[15:0];
    endfunction

    function automatic logic [15:0] node_target(input t_cfg c,
                                                input logic [NODE_IDX_W-1:0] i);
        logic [63:0] r;
        r = c.node_pair[i[2:1]];
        return i[0] ? r[63:48] : r[31:16];
    endfunction

endpackage

FILE: src/pdtm_cfg_regs.sv
// ----------------------------------------------------------------------------
// pdtm_cfg_regs: configuration register file
// Indexed write port; all registers reset to zero.
// ----------------------------------------------------------------------------
module pdtm_cfg_regs
    import pdtm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NODE_PAIR_A:  r_cfg.node_pair[0] <= i_cfg_wdata;
                CFG_NODE_PAIR_B:  r_cfg.node_pair[1] <= i_cfg_wdata;
                CFG_NODE_PAIR_C:  r_cfg.node_pair[2] <= i_cfg_wdata;
                CFG_NODE_PAIR_D:  r_cfg.node_pair[3] <= i_cfg_wdata;
                CFG_START_DUTY:   r_cfg.start_duty   <= i_cfg_wdata[14:0];
                CFG_STOP_DUTY:    r_cfg.stop_duty    <= i_cfg_wdata[14:0];
                CFG_FILTER_TICKS: r_cfg.filter_ticks <= i_cfg_wdata[15:0];
                CFG_INVERT_DUTY:  r_cfg.invert_duty  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/pdtm_ctrl.sv
// ----------------------------------------------------------------------------
// pdtm_ctrl: sequencing state machine
// Steps one transaction through capture, division, filter, map and
// interpolation; owns the input ready and the result valid.
// ----------------------------------------------------------------------------
module pdtm_ctrl
    import pdtm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_valid,
    output logic  o_s_ready,
    output logic  o_m_valid,
    input  logic  i_m_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_CAPT   = 10'b0000000010,
        ST_DIV1   = 10'b0000000100,
        ST_DUTY   = 10'b0000001000,
        ST_FILT   = 10'b0000010000,
        ST_MAP    = 10'b0000100000,
        ST_MUL    = 10'b0001000000,
        ST_DIV2   = 10'b0010000000,
        ST_INTERP = 10'b0100000000,
        ST_DONE   = 10'b1000000000
    } t_state;

    t_state                r_state, n_state;
    logic [STEP_CNT_W-1:0] r_cnt, n_cnt;
    logic                  r_out_valid, n_out_valid;
    logic                  w_out_free;

    assign w_out_free = !r_out_valid || i_m_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        o_s_ready   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.in_load = 1'b1;
                    n_state       = ST_CAPT;
                end
            end
            ST_CAPT: begin
                o_cmd.capt = 1'b1;
                if (i_stat.need_div) begin
                    n_cnt   = DIV1_STEPS;
                    n_state = ST_DIV1;
                end else begin
                    n_state = ST_FILT;
                end
            end
            ST_DIV1: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - STEP_CNT_W'(1);
                if (r_cnt == STEP_CNT_W'(1)) n_state = ST_DUTY;
            end
            ST_DUTY: begin
                o_cmd.duty_wr = 1'b1;
                n_state       = ST_FILT;
            end
            ST_FILT: begin
                o_cmd.filt = 1'b1;
                n_state    = ST_MAP;
            end
            ST_MAP: begin
                o_cmd.map = 1'b1;
                n_state   = i_stat.need_interp ? ST_MUL : ST_DONE;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = DIV2_STEPS;
                n_state   = ST_DIV2;
            end
            ST_DIV2: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - STEP_CNT_W'(1);
                if (r_cnt == STEP_CNT_W'(1)) n_state = ST_INTERP;
            end
            ST_INTERP: begin
                o_cmd.interp = 1'b1;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) n_out_valid = 1'b1;
        else if (i_m_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_valid = r_out_valid;

endmodule

FILE: src/pdtm_datapath.sv
// ----------------------------------------------------------------------------
// pdtm_datapath: capture filter, shared serial divider, hysteresis, table map
// Acts only on commands from the controller.
// ----------------------------------------------------------------------------
module pdtm_datapath
    import pdtm_pkg::*;
#(
    parameter int NODES             = 8,
    parameter int CAPTURE_TOLERANCE = 50
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_cap_ready,
    input  logic [15:0] i_high,
    input  logic [15:0] i_period,
    output logic [31:0] o_out_data
);

    localparam int SEL_W = $clog2(NODES);
    localparam int LAST  = NODES - 1;

    // tick state
    logic [15:0] r_prev_high, r_prev_period;
    logic [14:0] r_duty;
    logic        r_run;
    logic [15:0] r_stop_cnt, r_start_cnt;

    // latched transaction
    logic        r_cap_ready;
    logic [15:0] r_high, r_period;

    // serial divider: remainder below divisor whenever a division runs
    logic [15:0] r_rem, r_dlo, r_dvs, r_quo;

    // interpolation operands
    logic [15:0] r_t0, r_dt, r_dx, r_dd, r_target;
    logic        r_dec;
    logic [31:0] r_out;

    // capture check
    logic [15:0] w_dh, w_dp, w_per;
    logic        w_accept;

    always_comb begin
        w_dh     = (r_high > r_prev_high) ? (r_high - r_prev_high) : (r_prev_high - r_high);
        w_dp     = (r_period > r_prev_period) ? (r_period - r_prev_period)
                                              : (r_prev_period - r_period);
        w_accept = r_cap_ready && ({1'b0, w_dh} < 17'(CAPTURE_TOLERANCE))
                               && ({1'b0, w_dp} < 17'(CAPTURE_TOLERANCE));
        w_per    = (r_period == 16'd0) ? 16'd1 : r_period;
    end

    // divider step
    logic [16:0] w_trial;
    logic        w_qbit;
    logic [16:0] w_diff;

    always_comb begin
        w_trial = {r_rem, r_dlo[15]};
        w_diff  = w_trial - {1'b0, r_dvs};
        w_qbit  = (w_trial >= {1'b0, r_dvs});
    end

    // hysteresis
    logic        n_run;
    logic [15:0] n_stop_cnt, n_start_cnt;

    always_comb begin
        n_run       = r_run;
        n_stop_cnt  = r_stop_cnt;
        n_start_cnt = r_start_cnt;
        if (r_run && (r_duty < i_cfg.stop_duty)) begin
            if (r_stop_cnt > i_cfg.filter_ticks) n_run = 1'b0;
            else if (r_stop_cnt != CNT_SAT)      n_stop_cnt = r_stop_cnt + 16'd1;
        end else begin
            n_stop_cnt = '0;
        end
        // start check sees the flag as left by the stop check
        if (!n_run && (r_duty > i_cfg.start_duty)) begin
            if (r_start_cnt > i_cfg.filter_ticks) n_run = 1'b1;
            else if (r_start_cnt != CNT_SAT)      n_start_cnt = r_start_cnt + 16'd1;
        end else begin
            n_start_cnt = '0;
        end
    end

    // segment select: highest matching segment wins
    logic [15:0]      w_duty16, w_d0, w_d1, w_t0, w_t1, w_first_d, w_last_d;
    logic [SEL_W-1:0] w_sel;
    logic             w_found;

    always_comb begin
        w_duty16 = {1'b0, r_duty};
        w_sel    = '0;
        w_found  = 1'b0;
        for (int n = 1; n < NODES; n++) begin
            if ((w_duty16 > node_duty(i_cfg, NODE_IDX_W'(n - 1))) &&
                (w_duty16 <= node_duty(i_cfg, NODE_IDX_W'(n)))) begin
                w_sel   = SEL_W'(n);
                w_found = 1'b1;
            end
        end
        w_d0      = node_duty(i_cfg, NODE_IDX_W'(w_sel - SEL_W'(1)));
        w_d1      = node_duty(i_cfg, NODE_IDX_W'(w_sel));
        w_t0      = node_target(i_cfg, NODE_IDX_W'(w_sel - SEL_W'(1)));
        w_t1      = node_target(i_cfg, NODE_IDX_W'(w_sel));
        w_first_d = node_duty(i_cfg, NODE_IDX_W'(0));
        w_last_d  = node_duty(i_cfg, NODE_IDX_W'(LAST));
    end

    logic w_low_end, w_high_end;
    assign w_low_end  = (w_duty16 <= w_first_d);
    assign w_high_end = (w_duty16 > w_last_d);

    assign o_stat.need_div    = w_accept && (r_high < w_per);
    assign o_stat.need_interp = !w_low_end && !w_high_end && w_found;

    logic [31:0] w_prod;
    logic [15:0] w_qceil;
    assign w_prod  = r_dt * r_dx;
    assign w_qceil = r_quo + {15'd0, (r_rem != 16'd0)};

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_high   <= '0;
            r_prev_period <= '0;
            r_duty        <= '0;
            r_run         <= 1'b0;
            r_stop_cnt    <= '0;
            r_start_cnt   <= '0;
        end else begin
            if (i_cmd.capt && r_cap_ready) begin
                r_prev_high   <= r_high;
                r_prev_period <= w_accept ? w_per : r_period;
                if (w_accept && (r_high >= w_per)) begin
                    // ratio at or above one saturates
                    r_duty <= i_cfg.invert_duty ? 15'd0 : DUTY_MAX;
                end
            end
            if (i_cmd.duty_wr) begin
                r_duty <= i_cfg.invert_duty ? (DUTY_MAX - r_quo[14:0]) : r_quo[14:0];
            end
            if (i_cmd.filt) begin
                r_run       <= n_run;
                r_stop_cnt  <= n_stop_cnt;
                r_start_cnt <= n_start_cnt;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_cap_ready <= i_cap_ready;
            r_high      <= i_high;
            r_period    <= i_period;
        end
        if (i_cmd.capt) begin
            r_rem <= r_high;
            r_dlo <= '0;
            r_dvs <= w_per;
        end else if (i_cmd.mul) begin
            r_rem <= w_prod[31:16];
            r_dlo <= w_prod[15:0];
            r_dvs <= r_dd;
        end else if (i_cmd.div_step) begin
            r_rem <= w_qbit ? w_diff[15:0] : w_trial[15:0];
            r_dlo <= {r_dlo[14:0], 1'b0};
            r_quo <= {r_quo[14:0], w_qbit};
        end
        if (i_cmd.map) begin
            if (w_low_end) begin
                r_target <= node_target(i_cfg, NODE_IDX_W'(0));
            end else if (w_high_end || !w_found) begin
                r_target <= node_target(i_cfg, NODE_IDX_W'(LAST));
            end
            r_t0  <= w_t0;
            r_dec <= (w_t1 < w_t0);
            r_dt  <= (w_t1 < w_t0) ? (w_t0 - w_t1) : (w_t1 - w_t0);
            r_dx  <= w_duty16 - w_d0;
            r_dd  <= w_d1 - w_d0;
        end
        if (i_cmd.interp) begin
            // falling segment: subtract the rounded-up step to floor the result
            r_target <= r_dec ? (r_t0 - w_qceil) : (r_t0 + r_quo);
        end
        if (i_cmd.out_load) begin
            r_out <= {r_target, r_run, r_duty};
        end
    end

    assign o_out_data = r_out;

endmodule

FILE: src/pwm_duty_to_target_map.sv
// ----------------------------------------------------------------------------
// pwm_duty_to_target_map: PWM capture to run request and target command
// Top level; joins the configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one transaction per control tick. tuser = capture_ready,
//   tdata = high_count (15:0), period_count (31:16).
//   Master stream: one result transaction per input transaction.
//   tdata = duty_q15 (14:0), run_request (15), target_value (31:16).
//   Config port: write enable, 3-bit register index, 64-bit data; writes
//   are registered and must be issued only while the block is idle.
// Sequencing:
//   A tick runs capture, the duty division when needed (15 serial steps),
//   filter and map, then the interpolation division when needed (16 serial
//   steps), and loads the result register. One shared restoring divider
//   serves both divisions; one transaction is in work at a time and the
//   controller returns to its idle state before it takes the next.
// Reset (synchronous, active low): capture history, duty, run flag and
//   filter counters clear; all config registers clear; no result pending.
// Stall: a finished result sits in the output register; the next input
//   is accepted and worked on, and its result waits in the last state
//   until the output register is free.
// ----------------------------------------------------------------------------
module pwm_duty_to_target_map
    import pdtm_pkg::*;
#(
    parameter int NODES             = 8,
    parameter int CAPTURE_TOLERANCE = 50
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [31:0]           i_s_axis_tdata,  // high_count[15:0], period_count[31:16]
    input  logic                  i_s_axis_tuser,  // capture_ready[0]
    // master stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [31:0]           o_m_axis_tdata,  // duty_q15[14:0], run_request[15],
                                                   // target_value[31:16]
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg  w_cfg;
    t_cmd  w_cmd;
    t_stat w_stat;

    pdtm_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // controller: handshakes and sequencing
    pdtm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    // datapath: capture check, divider, filters, node table interpolation
    pdtm_datapath #(
        .NODES             (NODES),
        .CAPTURE_TOLERANCE (CAPTURE_TOLERANCE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cap_ready (i_s_axis_tuser),
        .i_high      (i_s_axis_tdata[15:0]),
        .i_period    (i_s_axis_tdata[31:16]),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule
